@@ rtl/core/i2cme_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cme_pkg - shared types and constants of the I2C master byte engine
// Command codes, segment counts and the state / result records.
// ----------------------------------------------------------------------------
package i2cme_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int DATA_SEGS     = 2 * BITS_PER_BYTE;
	localparam int BYTE_SEGS     = DATA_SEGS + 3;
	localparam int PHASE_W       = 5;
	localparam int TICK_W        = 16;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [PHASE_W-1:0] PHASE_IDLE = '0;

	localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;
	localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd5;

	typedef struct packed {
		logic scl;
		logic sda;
		logic en;
	} lines_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [1:0]         cmd;
		logic [TICK_W-1:0]  tick;
		logic [7:0]         shift;
		logic [7:0]         rx;
		logic               ack_flag;
		logic               ack_to_send;
		lines_t             lines;
	} eng_state_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} result_t;

endpackage

@@ rtl/core/i2cme_if.sv @@
// ----------------------------------------------------------------------------
// i2cme_cmd_if / i2cme_res_if - valid/ready channels of the byte engine
// Command tick channel in, line/status result channel out.
// ----------------------------------------------------------------------------
interface i2cme_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] command;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, cmd_valid, command, tx_byte, send_ack, sda_in,
		input ready);
	modport sink (input valid, cmd_valid, command, tx_byte, send_ack, sda_in,
		output ready);
endinterface

interface i2cme_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
		done_res, rx_byte, ack_seen, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
		done_res, rx_byte, ack_seen, output ready);
endinterface

@@ rtl/core/i2cme_step.sv @@
// ----------------------------------------------------------------------------
// i2cme_step - next-state logic for one engine tick
// Segment sequencing, bit shifting, sampling and line levels.
// ----------------------------------------------------------------------------
module i2cme_step (
	input  i2cme_pkg::eng_state_t              cur,
	input  logic [i2cme_pkg::TICK_W-1:0]       half_period,
	input  logic                               cmd_valid,
	input  logic [1:0]                         command,
	input  logic [7:0]                         tx_byte,
	input  logic                               send_ack,
	input  logic                               sda_in,
	output i2cme_pkg::eng_state_t              nxt,
	output i2cme_pkg::result_t                 result
);

	// line levels for segment seg (from 1) of command c
	function automatic i2cme_pkg::lines_t seg_lines(
		input logic [i2cme_pkg::PHASE_W-1:0] seg,
		input logic [1:0]                    c,
		input logic                          msb,
		input logic                          ats
	);
		i2cme_pkg::lines_t l;
		logic hi;
		logic ackl;
		hi   = ~seg[0];
		ackl = ~ats;
		if (c == i2cme_pkg::CMD_START) begin
			l = '{scl: 1'b1, sda: (seg == 5'd1), en: 1'b1};
		end else if (c == i2cme_pkg::CMD_STOP) begin
			l = '{scl: 1'b1, sda: (seg != 5'd1), en: 1'b1};
		end else if (seg <= i2cme_pkg::PHASE_W'(i2cme_pkg::DATA_SEGS)) begin
			if (c == i2cme_pkg::CMD_WRITE) l = '{scl: hi, sda: msb, en: 1'b1};
			else                           l = '{scl: hi, sda: 1'b1, en: 1'b0};
		end else if (seg <= i2cme_pkg::PHASE_W'(i2cme_pkg::DATA_SEGS + 2)) begin
			if (c == i2cme_pkg::CMD_WRITE) l = '{scl: hi, sda: 1'b1, en: 1'b0};
			else                           l = '{scl: hi, sda: ackl, en: 1'b1};
		end else begin
			if (c == i2cme_pkg::CMD_WRITE) l = '{scl: 1'b0, sda: 1'b1, en: 1'b0};
			else                           l = '{scl: 1'b0, sda: ackl, en: 1'b1};
		end
		return l;
	endfunction

	logic [i2cme_pkg::TICK_W-1:0]  hp;
	logic [i2cme_pkg::PHASE_W-1:0] phase_inc;
	logic [i2cme_pkg::PHASE_W-1:0] seg_total;
	logic                          done;

	assign hp        = (half_period == '0) ? i2cme_pkg::TICK_W'(1) : half_period;
	assign phase_inc = cur.phase + 5'd1;
	assign seg_total = (cur.cmd == i2cme_pkg::CMD_START || cur.cmd == i2cme_pkg::CMD_STOP)
		? 5'd2 : i2cme_pkg::PHASE_W'(i2cme_pkg::BYTE_SEGS);

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (cur.phase == i2cme_pkg::PHASE_IDLE) begin
			if (cmd_valid) begin
				nxt.cmd         = command;
				nxt.ack_to_send = send_ack;
				nxt.shift       = (command == i2cme_pkg::CMD_WRITE) ? tx_byte : 8'd0;
				nxt.phase       = 5'd1;
				nxt.tick        = i2cme_pkg::TICK_W'(1);
				nxt.lines       = seg_lines(5'd1, command, nxt.shift[7], send_ack);
			end
		end else if (cur.tick >= hp) begin
			// leaving a write data high segment: next bit
			if (cur.cmd == i2cme_pkg::CMD_WRITE && !cur.phase[0]
				&& cur.phase <= i2cme_pkg::PHASE_W'(i2cme_pkg::DATA_SEGS)) begin
				nxt.shift = {cur.shift[6:0], 1'b0};
			end
			nxt.tick = i2cme_pkg::TICK_W'(1);
			if (phase_inc > seg_total) begin
				if (cur.cmd == i2cme_pkg::CMD_STOP)
					nxt.lines = '{scl: 1'b1, sda: 1'b1, en: 1'b1};
				else
					nxt.lines = '{scl: 1'b0, sda: 1'b0, en: 1'b1};
				if (cur.cmd == i2cme_pkg::CMD_READ) nxt.rx = cur.shift;
				nxt.phase = i2cme_pkg::PHASE_IDLE;
				nxt.tick  = '0;
				done      = 1'b1;
			end else begin
				nxt.phase = phase_inc;
				nxt.lines = seg_lines(phase_inc, cur.cmd, nxt.shift[7], cur.ack_to_send);
			end
		end else begin
			nxt.tick = cur.tick + i2cme_pkg::TICK_W'(1);
		end

		// sample on the last tick of a sampled high segment
		if (nxt.phase != i2cme_pkg::PHASE_IDLE && nxt.tick >= hp) begin
			if (nxt.cmd == i2cme_pkg::CMD_READ && !nxt.phase[0]
				&& nxt.phase <= i2cme_pkg::PHASE_W'(i2cme_pkg::DATA_SEGS))
				nxt.shift = {nxt.shift[6:0], sda_in};
			if (nxt.cmd == i2cme_pkg::CMD_WRITE
				&& nxt.phase == i2cme_pkg::PHASE_W'(i2cme_pkg::DATA_SEGS + 2))
				nxt.ack_flag = ~sda_in;
		end

		result.scl_level        = nxt.lines.scl;
		result.sda_level        = nxt.lines.sda;
		result.sda_drive_enable = nxt.lines.en;
		result.busy_res         = (nxt.phase != i2cme_pkg::PHASE_IDLE);
		result.done_res         = done;
		result.rx_byte          = nxt.rx;
		result.ack_seen         = nxt.ack_flag;
	end

endmodule

@@ rtl/core/i2c_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine - tick-driven I2C master byte engine
// Start, stop, byte write and byte read with bus levels produced per tick.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       transaction
//  cmd      in   valid/ready     one bus tick: command request + sampled SDA
//  res      out  valid/ready     SCL/SDA levels, busy, done, rx byte, ack
//  apb      in   psel/penable    half_period_ticks at byte address 0
//
//  One transaction in gives one transaction out. A tick is taken every clock
//  while cmd.ready is high; the state update is one combinational pass into the
//  state registers and the result register, so the result is out in the cycle after.
//  The result register frees itself in the cycle it is read, so cmd.ready
//  drops only while a result waits and res.ready is low.
//  arst_n clears the engine to idle with SCL high, SDA high and driven,
//  and loads half_period_ticks with 5.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	i2cme_cmd_if.sink            cmd,
	i2cme_res_if.source          res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// config register
	logic [i2cme_pkg::TICK_W-1:0] half_period_q;
	logic                         hp_sel;

	assign pready = 1'b1;
	// word index is paddr[2]; any byte within word 0 selects the register
	assign hp_sel = (paddr[2] == i2cme_pkg::ADDR_HALF_PERIOD[2]);
	assign prdata = hp_sel ? {16'd0, half_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cme_pkg::HALF_PERIOD_RESET;
		end else if (psel && penable && pwrite && hp_sel) begin
			half_period_q <= pwdata[i2cme_pkg::TICK_W-1:0];
		end
	end

	// engine state and result register
	i2cme_pkg::eng_state_t state_q;
	i2cme_pkg::eng_state_t state_nxt;
	i2cme_pkg::result_t    result_nxt;
	i2cme_pkg::result_t    res_q;
	logic                  res_valid_q;
	logic                  in_acc;

	assign cmd.ready = !res_valid_q || res.ready;
	assign in_acc    = cmd.valid && cmd.ready;

	i2cme_step u_step (
		.cur         (state_q),
		.half_period (half_period_q),
		.cmd_valid   (cmd.cmd_valid),
		.command     (cmd.command),
		.tx_byte     (cmd.tx_byte),
		.send_ack    (cmd.send_ack),
		.sda_in      (cmd.sda_in),
		.nxt         (state_nxt),
		.result      (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= i2cme_pkg::PHASE_IDLE;
			state_q.cmd         <= i2cme_pkg::CMD_START;
			state_q.tick        <= '0;
			state_q.shift       <= '0;
			state_q.rx          <= '0;
			state_q.ack_flag    <= 1'b0;
			state_q.ack_to_send <= 1'b0;
			state_q.lines       <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
			res_valid_q         <= 1'b0;
		end else if (in_acc) begin
			state_q     <= state_nxt;
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) res_q <= result_nxt;
	end

	assign res.valid            = res_valid_q;
	assign res.scl_level        = res_q.scl_level;
	assign res.sda_level        = res_q.sda_level;
	assign res.sda_drive_enable = res_q.sda_drive_enable;
	assign res.busy_res         = res_q.busy_res;
	assign res.done_res         = res_q.done_res;
	assign res.rx_byte          = res_q.rx_byte;
	assign res.ack_seen         = res_q.ack_seen;

	// checks
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase <= i2cme_pkg::PHASE_W'(i2cme_pkg::BYTE_SEGS))
		else $error("phase beyond last segment");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == i2cme_pkg::PHASE_IDLE |-> state_q.tick == '0)
		else $error("tick counter running while idle");

	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && cmd.cmd_valid && state_q.phase == i2cme_pkg::PHASE_IDLE
		|=> state_q.phase == 5'd1 && res.busy_res && !res.done_res)
		else $error("idle engine did not take command");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res
		&& state_q.phase == i2cme_pkg::PHASE_IDLE)
		else $error("done reported while busy");

endmodule
